>>> rtl/fpa_pkg.sv
// Package with shared constants, operation codes and the result type for the Q24.8 ALU.
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int KIND_W        = 4;

    localparam logic [KIND_W-1:0] OP_ADD = 4'd0;
    localparam logic [KIND_W-1:0] OP_SUB = 4'd1;
    localparam logic [KIND_W-1:0] OP_MUL = 4'd2;
    localparam logic [KIND_W-1:0] OP_DIV = 4'd3;
    localparam logic [KIND_W-1:0] OP_MIN = 4'd4;
    localparam logic [KIND_W-1:0] OP_MAX = 4'd5;
    localparam logic [KIND_W-1:0] OP_INC = 4'd6;
    localparam logic [KIND_W-1:0] OP_DEC = 4'd7;
    localparam logic [KIND_W-1:0] OP_INT = 4'd8;
    localparam logic [KIND_W-1:0] OP_CMP = 4'd9;

    typedef struct packed {
        logic [31:0] value;
        logic        less;
        logic        equal;
        logic        greater;
        logic        div_by_zero;
        logic        saturated;
    } fpa_res_t;

endpackage

>>> rtl/fixed_point_q24_8_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Throughput: one operation per cycle unless the output stalls; the divider is a chain of restoring cells,
// one quotient bit per cell, so every cell holds a different item in flight.
// A stall at the output freezes the whole chain; the input is stalled with it.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
module fixed_point_q24_8_alu #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fpa_pkg::KIND_W-1:0] kind,
    input  logic signed [31:0]         operand_a,
    input  logic signed [31:0]         operand_b,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         value,
    output logic                       less,
    output logic                       equal,
    output logic                       greater,
    output logic                       div_by_zero,
    output logic                       saturated
);
    import fpa_pkg::*;

    // The quotient of (|a| << F) by |b| has NW bits, one cell per bit.
    localparam int NW     = 32 + FRACTION_BITS;
    localparam int STAGES = NW + 2;

    logic              adv;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    // The whole pipe moves together unless a held result is being refused.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    fpa_res_t          side_f;
    logic [NW-1:0]     num_f;
    logic [31:0]       den_f;
    logic              neg_f;
    logic              div_f;
    logic              mul_f;
    logic signed [63:0] prod_f;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_front (
        .clk(clk), .adv(adv), .kind(kind), .operand_a(operand_a),
        .operand_b(operand_b), .side_reg(side_f), .num_reg(num_f),
        .den_reg(den_f), .neg_reg(neg_f), .div_reg(div_f),
        .mul_reg(mul_f), .prod_reg(prod_f)
    );

    // Multiply rounding is done in the slot after the multiplier register, so the
    // result joins the side channel that travels with the divider cells.
    fpa_res_t   side_m;
    logic [63:0] pmag;
    logic [63:0] prnd;

    always_comb
    begin
        pmag   = prod_f[63] ? 64'(-prod_f) : 64'(prod_f);
        prnd   = (pmag + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        side_m = side_f;
        if (mul_f)
        begin
            if (prod_f[63])
            begin
                if (prnd > 64'h80000000)
                begin
                    side_m.value = 32'h80000000; side_m.saturated = 1'b1;
                end
                else
                    side_m.value = 32'(-prnd);
            end
            else if (prnd > 64'h7fffffff)
            begin
                side_m.value = 32'h7fffffff; side_m.saturated = 1'b1;
            end
            else
                side_m.value = prnd[31:0];
        end
    end

    logic [NW-1:0]  c_num  [NW+1];
    logic [32:0]    c_rem  [NW+1];
    logic [31:0]    c_den  [NW+1];
    logic [NW-1:0]  c_quo  [NW+1];
    fpa_res_t       c_side [NW+1];
    logic           c_neg  [NW+1];
    logic           c_div  [NW+1];

    assign c_num[0]  = num_f;
    assign c_rem[0]  = '0;
    assign c_den[0]  = den_f;
    assign c_quo[0]  = '0;
    assign c_side[0] = side_m;
    assign c_neg[0]  = neg_f;
    assign c_div[0]  = div_f;

    // Cells take quotient bits from the most significant down.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        fpa_div_cell #(.NW(NW), .DW(32), .BIT(NW - 1 - i)) u_cell (
            .clk(clk), .adv(adv),
            .num_in(c_num[i]), .rem_in(c_rem[i]), .den_in(c_den[i]),
            .quo_in(c_quo[i]), .side_in(c_side[i]), .neg_in(c_neg[i]),
            .div_in(c_div[i]),
            .num_out(c_num[i+1]), .rem_out(c_rem[i+1]), .den_out(c_den[i+1]),
            .quo_out(c_quo[i+1]), .side_out(c_side[i+1]), .neg_out(c_neg[i+1]),
            .div_out(c_div[i+1])
        );
    end

    // Round half away from zero: add one when twice the remainder reaches the divisor.
    logic [NW:0]  q_rnd;
    fpa_res_t     res_next;
    fpa_res_t     res_reg;

    always_comb
    begin
        q_rnd = {1'b0, c_quo[NW]} +
                (({c_rem[NW], 1'b0} >= {2'b00, c_den[NW]}) ? 1'b1 : 1'b0);
        res_next = c_side[NW];
        if (c_div[NW])
        begin
            if (c_neg[NW])
            begin
                if (q_rnd > (NW+1)'(33'h080000000))
                begin
                    res_next.value = 32'h80000000; res_next.saturated = 1'b1;
                end
                else
                    res_next.value = 32'(-q_rnd);
            end
            else if (q_rnd > (NW+1)'(32'h7fffffff))
            begin
                res_next.value = 32'h7fffffff; res_next.saturated = 1'b1;
            end
            else
                res_next.value = q_rnd[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    // Stage map: front register, NW cells (multiplier rounding folded into the
    // input of cell 0), result register; one valid bit per stage.
    assign out_valid   = vld_reg[STAGES-1];
    assign value       = res_reg.value;
    assign less        = res_reg.less;
    assign equal       = res_reg.equal;
    assign greater     = res_reg.greater;
    assign div_by_zero = res_reg.div_by_zero;
    assign saturated   = res_reg.saturated;
endmodule

>>> rtl/fpa_div_cell.sv
// One restoring division cell: develops one quotient bit and passes the rest on.
module fpa_div_cell #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          adv,
    input  logic [NW-1:0] num_in,
    input  logic [DW:0]   rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [NW-1:0] quo_in,
    input  fpa_pkg::fpa_res_t side_in,
    input  logic          neg_in,
    input  logic          div_in,
    output logic [NW-1:0] num_out,
    output logic [DW:0]   rem_out,
    output logic [DW-1:0] den_out,
    output logic [NW-1:0] quo_out,
    output fpa_pkg::fpa_res_t side_out,
    output logic          neg_out,
    output logic          div_out
);
    import fpa_pkg::*;

    logic [DW+1:0] trial;
    logic [DW+1:0] diff;
    logic          fits;
    logic [DW:0]   rem_next;
    logic [NW-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_in, num_in[BIT]};
        diff     = trial - {2'b00, den_in};
        fits     = !diff[DW+1];
        rem_next = fits ? diff[DW:0] : trial[DW:0];
        quo_next = quo_in;
        quo_next[BIT] = fits;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_out  <= num_in;
            rem_out  <= rem_next;
            den_out  <= den_in;
            quo_out  <= quo_next;
            side_out <= side_in;
            neg_out  <= neg_in;
            div_out  <= div_in;
        end
    end
endmodule

>>> rtl/fpa_front.sv
// Front stage: simple operations, multiplier and divider operand set-up.
module fpa_front #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int NW = 32 + FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [fpa_pkg::KIND_W-1:0]    kind,
    input  logic signed [31:0]            operand_a,
    input  logic signed [31:0]            operand_b,
    output fpa_pkg::fpa_res_t             side_reg,
    output logic [NW-1:0]                 num_reg,
    output logic [31:0]                   den_reg,
    output logic                          neg_reg,
    output logic                          div_reg,
    output logic                          mul_reg,
    output logic signed [63:0]            prod_reg
);
    import fpa_pkg::*;

    fpa_res_t          side_next;
    logic signed [32:0] sum;
    logic [31:0]       mag_a;
    logic [31:0]       mag_b;
    logic [31:0]       tr;
    logic              lt;

    always_comb
    begin
        mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
        mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
        lt    = operand_a < operand_b;
        sum   = '0;
        side_next = '0;
        tr    = mag_a >> FRACTION_BITS;
        unique case (kind)
            OP_ADD, OP_SUB:
            begin
                sum = (kind == OP_ADD) ? 33'(operand_a) + 33'(operand_b)
                                       : 33'(operand_a) - 33'(operand_b);
                if (sum > 33'sd2147483647)
                begin
                    side_next.value = 32'h7fffffff; side_next.saturated = 1'b1;
                end
                else if (sum < -33'sd2147483648)
                begin
                    side_next.value = 32'h80000000; side_next.saturated = 1'b1;
                end
                else
                    side_next.value = sum[31:0];
            end
            OP_DIV: side_next.div_by_zero = (operand_b == 32'sd0);
            OP_MIN: side_next.value = (lt || operand_a == operand_b) ? operand_a : operand_b;
            OP_MAX: side_next.value = (!lt) ? operand_a : operand_b;
            OP_INC: side_next.value = operand_a + 32'sd1;
            OP_DEC: side_next.value = operand_a - 32'sd1;
            OP_INT: side_next.value = operand_a[31] ? -tr : tr;
            OP_CMP:
            begin
                side_next.less    = lt;
                side_next.equal   = operand_a == operand_b;
                side_next.greater = !lt && operand_a != operand_b;
            end
            default: side_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            num_reg  <= {mag_a, {FRACTION_BITS{1'b0}}};
            den_reg  <= mag_b;
            neg_reg  <= operand_a[31] ^ operand_b[31];
            div_reg  <= (kind == OP_DIV) && (operand_b != 32'sd0);
            mul_reg  <= (kind == OP_MUL);
            prod_reg <= operand_a * operand_b;
        end
    end
endmodule

>>> test/tb_fixed_point_q24_8_alu.sv
// Self-checking testbench for the Q24.8 fixed-point ALU with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_fixed_point_q24_8_alu;
    import fpa_pkg::*;

    localparam int LATENCY    = FRAC_BITS_DEF + 33;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 650;

    // Queue of expected outcomes, in the package's result layout, with a failure count.
    class alu_scoreboard;
        fpa_res_t pending[$];
        int       failures;

        function new();
            failures = 0;
        endfunction

        // Clips a wide signed value to the 32-bit range and flags the saturation.
        static function fpa_res_t clip(longint v, fpa_res_t r);
            if (v > 64'sd2147483647)
            begin
                r.value = 32'h7fffffff;
                r.saturated = 1'b1;
            end
            else if (v < -64'sd2147483648)
            begin
                r.value = 32'h80000000;
                r.saturated = 1'b1;
            end
            else
                r.value = v[31:0];
            return r;
        endfunction

        static function fpa_res_t compute(logic [3:0] op, logic signed [31:0] a,
                                          logic signed [31:0] b);
            fpa_res_t r;
            longint sa, sb, prod;
            longint unsigned mag, num, den, q;
            sa = a;
            sb = b;
            r = '0;
            case (op)
                OP_ADD: r = clip(sa + sb, r);
                OP_SUB: r = clip(sa - sb, r);
                OP_MUL:
                begin
                    prod = sa * sb;
                    mag = prod < 0 ? -prod : prod;
                    mag = (mag + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
                    r = clip(prod < 0 ? -longint'(mag) : longint'(mag), r);
                end
                OP_DIV:
                begin
                    if (b == 0)
                        r.div_by_zero = 1'b1;
                    else
                    begin
                        num = (sa < 0 ? -sa : sa) << FRAC_BITS_DEF;
                        den = sb < 0 ? -sb : sb;
                        q = (2 * num + den) / (2 * den);
                        r = clip(((sa < 0) != (sb < 0)) ? -longint'(q) : longint'(q), r);
                    end
                end
                OP_MIN: r.value = (a <= b) ? a : b;
                OP_MAX: r.value = (a >= b) ? a : b;
                OP_INC: r.value = a + 32'd1;
                OP_DEC: r.value = a - 32'd1;
                OP_INT:
                begin
                    mag = (sa < 0 ? -sa : sa) >> FRAC_BITS_DEF;
                    r.value = sa < 0 ? -mag[31:0] : mag[31:0];
                end
                OP_CMP:
                begin
                    r.less    = a < b;
                    r.equal   = a == b;
                    r.greater = a > b;
                end
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_operation(logic [3:0] op, logic signed [31:0] a,
                                     logic signed [31:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        function void check_result(fpa_res_t got);
            fpa_res_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: value %h", got.value);
                failures++;
                return;
            end
            exp = pending.pop_front();
            if (got.value !== exp.value)
            begin
                $error("value: expected %h, got %h", exp.value, got.value);
                failures++;
            end
            if (got.less !== exp.less)
            begin
                $error("less: expected %b, got %b", exp.less, got.less);
                failures++;
            end
            if (got.equal !== exp.equal)
            begin
                $error("equal: expected %b, got %b", exp.equal, got.equal);
                failures++;
            end
            if (got.greater !== exp.greater)
            begin
                $error("greater: expected %b, got %b", exp.greater, got.greater);
                failures++;
            end
            if (got.div_by_zero !== exp.div_by_zero)
            begin
                $error("div_by_zero: expected %b, got %b", exp.div_by_zero, got.div_by_zero);
                failures++;
            end
            if (got.saturated !== exp.saturated)
            begin
                $error("saturated: expected %b, got %b", exp.saturated, got.saturated);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [KIND_W-1:0]  kind = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] value;
    logic               less, equal, greater, div_by_zero, saturated;

    fixed_point_q24_8_alu i_dut (.*);

    always #4 clk = ~clk;

    alu_scoreboard board = new();

    // Idling rates in percent; the phase the stimulus is in sets them.
    int send_idle_pct = 12;
    int recv_idle_pct = 68;
    // When set, the receiver's own process holds stall high for a long stretch.
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    // Results are sampled at the rising edge; a transfer happens when valid is high and
    // stall is low. The stall for the next cycle is then chosen at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{value, less, equal, greater, div_by_zero, saturated});
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            out_stall <= 1'b1;
            repeat (3 * LATENCY) @(negedge clk);
            hold_request = 1'b0;
            out_stall <= 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one item from the falling edge and holds it until the transfer.
    task automatic send_operation(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_operation(op, a, b);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // Operands mostly near the edges of the range or of small magnitude.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(2047) - 1024;
            2: return 32'h7fffffff - $urandom_range(300);
            3: return 32'h80000000 + $urandom_range(300);
            4: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom_range(3) == 0 ? 32'd0 : 32'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [31:0] a;
        for (int n = 0; n < count; n++)
        begin
            a = pick_operand();
            // Equal operands now and then, for ties and compare-equal.
            send_operation($urandom_range(15) < 14 ? 4'($urandom_range(9)) : 4'($urandom()),
                           a, $urandom_range(7) == 0 ? a : pick_operand());
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: range extremes, rounding ties, divide by zero and unused selectors.
        send_operation(OP_ADD, 32'h7fffffff, 32'h00000001);
        send_operation(OP_ADD, 32'h80000000, 32'hffffffff);
        send_operation(OP_SUB, 32'h80000000, 32'h00000001);
        send_operation(OP_SUB, 32'h7fffffff, 32'h80000000);
        send_operation(OP_MUL, 32'h00000180, 32'h00000080);
        send_operation(OP_MUL, 32'hffffff80, 32'h00000001);
        send_operation(OP_MUL, 32'h80000000, 32'h80000000);
        send_operation(OP_MUL, 32'h7fffffff, 32'h80000000);
        send_operation(OP_DIV, 32'h00000100, 32'h00000000);
        send_operation(OP_DIV, 32'h80000000, 32'h00000001);
        send_operation(OP_DIV, 32'h00000001, 32'hfffffe00);
        send_operation(OP_DIV, 32'h80000000, 32'h80000000);
        send_operation(OP_DIV, 32'h7fffffff, 32'hffffffff);
        send_operation(OP_MIN, 32'h00000005, 32'h00000005);
        send_operation(OP_MAX, 32'h80000000, 32'h7fffffff);
        send_operation(OP_INC, 32'h7fffffff, 32'hffffffff);
        send_operation(OP_DEC, 32'h80000000, 32'h00000000);
        send_operation(OP_INT, 32'hfffffe80, 32'h0);
        send_operation(OP_INT, 32'h80000000, 32'h0);
        send_operation(OP_CMP, 32'h80000000, 32'h7fffffff);
        send_operation(OP_CMP, 32'h12345678, 32'h12345678);
        send_operation(OP_CMP, 32'h00000001, 32'hffffffff);
        send_operation(4'd10, 32'hffffffff, 32'hffffffff);
        send_operation(4'd15, 32'h7fffffff, 32'h00000001);

        random_phase(200);
        // The sender pauses until every expected result has come.
        drain_results();

        // Long receiver hold-off while items keep coming, so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_request = 1'b1;
        random_phase(80);

        send_idle_pct = 68;
        recv_idle_pct = 12;
        random_phase(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(RANDOM_ITEMS - 480);

        drain_results();
        repeat (LATENCY + 10) @(negedge clk);

        if (board.failures == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
